// File: design/format_string_integer_printer_defines.svh
// Assertion helpers shared by the formatter modules.
`ifndef FORMAT_STRING_INTEGER_PRINTER_DEFINES_SVH
`define FORMAT_STRING_INTEGER_PRINTER_DEFINES_SVH

// Checked out of reset only.
`define FSIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define FSIP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/fsip_pkg.sv
`timescale 1ns / 1ps
package fsip_pkg;

  localparam int unsigned MAX_WIDTH_DEFAULT   = 48;
  localparam int unsigned MAX_WIDTH_LIMIT     = 64;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
  localparam int unsigned FW_W                = $clog2(MAX_WIDTH_LIMIT + 1);
  localparam int unsigned HEX_DIGITS          = 8;
  localparam int unsigned DEC_DIGITS          = 10;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] HEX_BASE   = 8'h60;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_L       = 8'h6C;
  localparam logic [7:0] CH_X       = 8'h78;

  typedef enum logic [1:0] {
    CMD_ECHO,
    CMD_HEX,
    CMD_DEC
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        ch;
    logic [31:0]       value;
    logic              neg;
    logic [FW_W-1:0]   width;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ECHO,
    B_HEX_SKIP,
    B_HEX_OUT,
    B_DEC_DIV,
    B_DEC_PAD,
    B_DEC_SIGN,
    B_DEC_DIGIT
  } back_state_e;

endpackage

// File: design/format_string_integer_printer.sv
`timescale 1ns / 1ps
// An echoed byte passes through the command queue, the back end's echo state and the output register
// before it reaches the output. Bytes leave at 1 byte per cycle while the output is ready; the idle
// state fetches each command from the queue, hex skips up to 7 leading zero digits, and decimal
// divides by ten once per digit, then emits the space padding. A byte-less item queues no command.
// The front accepts while the command queue has room. Reset clears conversion state.
module format_string_integer_printer import fsip_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  fmt_char_i,
  input  logic [31:0] argument_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_o
);

  logic push, q_full, q_valid, pop;
  cmd_t push_cmd, head_cmd;

  fsip_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .fmt_char_i (fmt_char_i),
    .argument_i (argument_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  fsip_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  fsip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule

// File: design/fsip_front.sv
`timescale 1ns / 1ps
module fsip_front import fsip_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  fmt_char_i,
  input  logic [31:0] argument_i,
  input  logic        q_full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic            in_conv_q, in_conv_d;
  logic [FW_W-1:0] fw_q, fw_d;
  logic            accept;
  logic [10:0]     wide_w;
  logic [31:0]     mag;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wide_w     = 11'(fw_q) * 11'd10 + 11'(fmt_char_i[3:0]);
  assign mag        = argument_i[31] ? (32'd0 - argument_i) : argument_i;

  always_comb begin
    in_conv_d   = in_conv_q;
    fw_d        = fw_q;
    push_o      = 1'b0;
    cmd_o.kind  = CMD_ECHO;
    cmd_o.ch    = fmt_char_i;
    cmd_o.value = mag;
    cmd_o.neg   = argument_i[31];
    cmd_o.width = fw_q;
    if (accept) begin
      priority if (fmt_char_i == CH_NUL) begin
        in_conv_d = 1'b0;
        fw_d      = '0;
        push_o    = 1'b1;
      end else if (!in_conv_q) begin
        if (fmt_char_i == CH_PERCENT) begin
          in_conv_d = 1'b1;
          fw_d      = '0;
        end else begin
          push_o = 1'b1;
        end
      end else if (fmt_char_i >= CH_ZERO && fmt_char_i <= CH_NINE) begin
        fw_d = (wide_w > 11'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : FW_W'(wide_w);
      end else if (fmt_char_i == CH_D) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_DEC;
        in_conv_d  = 1'b0;
        fw_d       = '0;
      end else if (fmt_char_i == CH_X) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_HEX;
        in_conv_d  = 1'b0;
        fw_d       = '0;
      end else if (fmt_char_i == CH_L) begin
        push_o      = 1'b1;
        cmd_o.kind  = CMD_HEX;
        cmd_o.value = argument_i;
        in_conv_d   = 1'b0;
        fw_d        = '0;
      end else begin
        // any other byte inside a conversion is ignored
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_conv_q <= 1'b0;
      fw_q      <= '0;
    end else begin
      in_conv_q <= in_conv_d;
      fw_q      <= fw_d;
    end
  end

endmodule

// File: design/fsip_queue.sv
`timescale 1ns / 1ps
module fsip_queue import fsip_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  `include "format_string_integer_printer_defines.svh"

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `FSIP_ASSERT(a_no_overflow, push_i |-> !full_o, "command pushed into full queue")
  `FSIP_ASSERT(a_count_range, count_q <= CntW'(QUEUE_DEPTH), "queue count out of range")
  `FSIP_ASSERT(a_full_has_item, full_o |-> valid_o, "full queue reports no item")

endmodule

// File: design/fsip_back.sv
`timescale 1ns / 1ps
module fsip_back import fsip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_o
);

  `include "format_string_integer_printer_defines.svh"

  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  back_state_e     state_q, state_d;
  logic [31:0]     val_q;
  logic [7:0]      ch_q;
  logic            neg_q;
  logic [FW_W-1:0] width_q;
  logic [FW_W-1:0] pad_q;
  logic [3:0]      cnt_q;
  logic [3:0]      k_q;
  logic [3:0]      digits_q [DEC_DIGITS];

  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;

  logic            emit_ok, emit_req, emit_last;
  logic [7:0]      emit_char;
  logic            skip_zero;
  logic [63:0]     prod;
  logic [31:0]     quo, quo10;
  logic [3:0]      rem;
  logic [FW_W-1:0] len, pad_calc;
  logic [3:0]      top_nib, cur_dig;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + 8'(d);
    end
    return HEX_BASE + 8'(d) - 8'd9;
  endfunction

  assign emit_ok   = !out_valid_q || out_ready_i;
  assign top_nib   = val_q[31:28];
  assign skip_zero = (cnt_q > 4'd1) && (top_nib == 4'd0);
  assign prod      = 64'(val_q) * 64'(RECIP10);
  assign quo       = 32'(prod[63:35]);
  assign quo10     = (quo << 3) + (quo << 1);
  assign rem       = val_q[3:0] - quo10[3:0];
  assign len       = FW_W'(k_q) + FW_W'(1) + FW_W'(neg_q);
  assign pad_calc  = (width_q > len) ? (width_q - len) : '0;
  assign cur_dig   = digits_q[4'(k_q - 4'd1)];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_ECHO: state_d = B_ECHO;
            CMD_HEX:  state_d = B_HEX_SKIP;
            CMD_DEC:  state_d = B_DEC_DIV;
            default:  state_d = B_IDLE;
          endcase
        end
      end
      B_ECHO:      if (emit_ok) state_d = B_IDLE;
      B_HEX_SKIP:  if (!skip_zero) state_d = B_HEX_OUT;
      B_HEX_OUT:   if (emit_ok && cnt_q == 4'd1) state_d = B_IDLE;
      B_DEC_DIV:   if (quo == '0) state_d = B_DEC_PAD;
      B_DEC_PAD:   if (pad_q == '0) state_d = neg_q ? B_DEC_SIGN : B_DEC_DIGIT;
      B_DEC_SIGN:  if (emit_ok) state_d = B_DEC_DIGIT;
      B_DEC_DIGIT: if (emit_ok && k_q == 4'd1) state_d = B_IDLE;
      default:     state_d = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    emit_req  = 1'b0;
    emit_char = ch_q;
    emit_last = 1'b0;
    unique case (state_q)
      B_IDLE:     cmd_pop_o = cmd_valid_i;
      B_ECHO: begin
        emit_req  = 1'b1;
        emit_last = 1'b1;
      end
      B_HEX_OUT: begin
        emit_req  = 1'b1;
        emit_char = hex_char(top_nib);
        emit_last = (cnt_q == 4'd1);
      end
      B_DEC_PAD: begin
        emit_req  = (pad_q != '0);
        emit_char = CH_SPACE;
      end
      B_DEC_SIGN: begin
        emit_req  = 1'b1;
        emit_char = CH_MINUS;
      end
      B_DEC_DIGIT: begin
        emit_req  = 1'b1;
        emit_char = CH_ZERO + 8'(cur_dig);
        emit_last = (k_q == 4'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        val_q   <= cmd_i.value;
        ch_q    <= cmd_i.ch;
        neg_q   <= cmd_i.neg;
        width_q <= cmd_i.width;
      end
      B_HEX_SKIP: if (skip_zero) val_q <= val_q << 4;
      B_HEX_OUT:  if (emit_ok) val_q <= val_q << 4;
      B_DEC_DIV: begin
        digits_q[k_q] <= rem;
        val_q         <= quo;
        pad_q         <= pad_calc;
      end
      B_DEC_PAD:  if (emit_ok && pad_q != '0) pad_q <= pad_q - 1'b1;
      default: ;
    endcase
    if (emit_req && emit_ok) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        B_IDLE: begin
          cnt_q <= 4'(HEX_DIGITS);
          k_q   <= '0;
        end
        B_HEX_SKIP:  if (skip_zero) cnt_q <= cnt_q - 1'b1;
        B_HEX_OUT:   if (emit_ok) cnt_q <= cnt_q - 1'b1;
        B_DEC_DIV:   k_q <= k_q + 1'b1;
        B_DEC_DIGIT: if (emit_ok) k_q <= k_q - 1'b1;
        default: ;
      endcase
      if (emit_req && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  `FSIP_ASSERT(a_digit_left, (state_q == B_DEC_DIGIT) |-> (k_q != 4'd0), "no decimal digit left")
  `FSIP_ASSERT(a_hex_left, (state_q == B_HEX_OUT) |-> (cnt_q != 4'd0), "no hex digit left")
  `FSIP_ASSERT(a_k_range, k_q <= 4'(DEC_DIGITS), "digit count out of range")

endmodule
